FILE: rtl/bda_pkg.sv
// shared constants and state type for the binary to decimal ascii converter
`default_nettype none

package bda_pkg;

    localparam int NUM_WIDTH          = 31;
    localparam int CHAR_WIDTH         = 6;
    localparam int BIT_CNT_W          = $clog2(NUM_WIDTH);
    localparam int MAX_DIGITS_DEFAULT = 10;
    localparam int DIGIT_SLOTS        = 10;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'h30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/binary_to_decimal_ascii.sv
// binary to decimal ascii converter, shift-and-add-3 then digit emission
//
//  channel   | ports                        | handshake
//  ----------+------------------------------+----------------------------------
//  input     | number_in                    | taken on start high, busy low
//  result    | digit_char, is_last          | one cycle each, marked by strobe
//
// a word is shifted in one input bit per conversion cycle, then MAX_DIGITS digits
// (held to 1..10) are emitted, most significant digit first; busy is high through
// conversion and emission, so a new word is taken only after the last one is done
// leading zero digits still take their emission cycle but give no strobe; each digit
// shows in the cycle after its emission cycle, the final one as busy falls
// rst_n clears control state at once, busy is low after reset; the receiver cannot stall
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = bda_pkg::MAX_DIGITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [bda_pkg::NUM_WIDTH-1:0]   number_in,
    output logic                                 strobe,
    output logic      [bda_pkg::CHAR_WIDTH-1:0]  digit_char,
    output logic                                 is_last
);

    localparam int DIGITS = (MAX_DIGITS > bda_pkg::DIGIT_SLOTS) ? bda_pkg::DIGIT_SLOTS
                          : ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
    localparam int BCD_W  = DIGITS * 4;
    localparam int DCNT_W = $clog2(DIGITS + 1);

    bda_pkg::state_t state_reg, state_next;

    logic [bda_pkg::NUM_WIDTH-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]               bcd_reg, bcd_next;
    logic [bda_pkg::BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DCNT_W-1:0]              dig_cnt_reg, dig_cnt_next;
    logic                           started_reg, started_next;
    logic                           strobe_reg, strobe_next;
    logic [bda_pkg::CHAR_WIDTH-1:0] digit_char_reg, digit_char_next;
    logic                           is_last_reg, is_last_next;

    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       top_digit;
    logic             last_digit;
    logic             conv_done;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        logic [3:0] d;
        d = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    assign top_digit  = bcd_reg[BCD_W-1 -: 4];
    assign last_digit = (dig_cnt_reg == DCNT_W'(1));
    assign conv_done  = (bit_cnt_reg == bda_pkg::BIT_CNT_W'(bda_pkg::NUM_WIDTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bda_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = bda_pkg::ST_CONV;
            end
            bda_pkg::ST_CONV:
            begin
                if (conv_done)
                    state_next = bda_pkg::ST_EMIT;
            end
            bda_pkg::ST_EMIT:
            begin
                if (last_digit)
                    state_next = bda_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bda_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        bin_next        = bin_reg;
        bcd_next        = bcd_reg;
        bit_cnt_next    = bit_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        started_next    = started_reg;
        strobe_next     = 1'b0;
        digit_char_next = digit_char_reg;
        is_last_next    = is_last_reg;
        case (state_reg)
            bda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    bin_next     = number_in;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                end
            end
            bda_pkg::ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[bda_pkg::NUM_WIDTH-1]};
                bin_next     = {bin_reg[bda_pkg::NUM_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (conv_done)
                begin
                    dig_cnt_next = DCNT_W'(DIGITS);
                    started_next = 1'b0;
                end
            end
            bda_pkg::ST_EMIT:
            begin
                // skip leading zeros, but always give the final digit
                strobe_next     = started_reg || (top_digit != 4'd0) || last_digit;
                digit_char_next = bda_pkg::ASCII_ZERO + {2'b00, top_digit};
                is_last_next    = last_digit;
                started_next    = strobe_next;
                bcd_next        = bcd_reg << 4;
                dig_cnt_next    = dig_cnt_reg - 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bda_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            started_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            started_reg <= started_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg        <= bin_next;
        bcd_reg        <= bcd_next;
        digit_char_reg <= digit_char_next;
        is_last_reg    <= is_last_next;
    end

    assign busy       = (state_reg != bda_pkg::ST_IDLE);
    assign strobe     = strobe_reg;
    assign digit_char = digit_char_reg;
    assign is_last    = is_last_reg;

`ifndef SYNTHESIS
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == bda_pkg::ST_EMIT))
        else $error("digit strobe without emission");

    a_last_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && is_last_reg) |-> (state_reg == bda_pkg::ST_IDLE))
        else $error("final digit while still busy");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (digit_char_reg >= bda_pkg::ASCII_ZERO &&
                        digit_char_reg <= bda_pkg::ASCII_ZERO + 6'd9))
        else $error("digit out of decimal range");

    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == bda_pkg::ST_CONV && bit_cnt_reg == '0))
        else $error("accepted word did not start conversion");
`endif

endmodule

`default_nettype wire
